[rtl/core/stl_pkg.sv]
package stl_pkg;

  // lexer modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_MINUS,
    MODE_POINT,
    MODE_NUMBER,
    MODE_HASH,
    MODE_ATOM,
    MODE_STRING
  } mode_t;

  // token kinds as seen on the output
  typedef enum logic [2:0] {
    KIND_NUMBER = 3'd0,
    KIND_BOOL   = 3'd1,
    KIND_OPEN   = 3'd2,
    KIND_CLOSE  = 3'd3,
    KIND_QUOTE  = 3'd4,
    KIND_STRING = 3'd5,
    KIND_ATOM   = 3'd6
  } kind_t;

  // character codes
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // results one byte can cause, and depth of the result queue
  localparam int MAX_RESULTS = 3;
  localparam int Q_DEPTH     = 4;

  // one result word
  typedef struct packed {
    logic       empty;
    logic       last;
    logic       first;
    kind_t      kind;
    logic [7:0] lex;
    logic       run_last;
  } res_t;

  // lexer state
  typedef struct packed {
    mode_t      mode;
    logic [7:0] h0;
    logic [7:0] h1;
    logic [1:0] hc;
    logic       hs;
    logic       ps;
  } lex_st_t;

  // state plus the results built so far for one byte
  typedef struct packed {
    lex_st_t    s;
    res_t [2:0] r;
    logic [1:0] n;
  } step_t;

endpackage

[rtl/core/sexpr_token_lexer_top.sv]
// s-expression lexer: one source byte in, up to three result words out.
// the result words of a byte are written into the registered queue when it is taken.
// throughput: one byte per cycle while each byte gives at most one word and the
// output drains; the output side moves one word per cycle while m_tready is high,
// from a four-entry queue, and s_tready drops while more than one word waits there.
// reset (rst, synchronous): lexer back to idle, hold count and queue emptied.
module sexpr_token_lexer_top
  import stl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] character
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] lexeme_byte
  output logic [5:0] m_tuser,   // [2:0] token_kind, [3] token_first, [4] token_last,
                                // [5] empty_lexeme
  output logic       m_tlast    // run_last
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  // character classes
  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return is_space(c) || c == CH_OPEN || c == CH_CLOSE;
  endfunction

  // append one result word, at most three per byte
  function automatic step_t push(input step_t x, input kind_t k, input logic [7:0] b,
                                 input logic f, input logic l, input logic e);
    step_t y;
    y = x;
    if (y.n < 2'd3) begin
      y.r[y.n].kind     = k;
      y.r[y.n].lex      = b;
      y.r[y.n].first    = f;
      y.r[y.n].last     = l;
      y.r[y.n].empty    = e;
      y.r[y.n].run_last = 1'b0;
      y.n               = y.n + 2'd1;
    end
    return y;
  endfunction

  // send out the held characters
  function automatic step_t emit_held(input step_t x, input kind_t k, input logic ends);
    step_t y;
    y = x;
    if (x.s.hc != 2'd0) begin
      y = push(y, k, x.s.h0, x.s.hs, ends && x.s.hc == 2'd1, 1'b0);
    end
    if (x.s.hc[1]) begin
      y = push(y, k, x.s.h1, 1'b0, ends, 1'b0);
    end
    y.s.hc = 2'd0;
    y.s.hs = 1'b0;
    return y;
  endfunction

  // keep a character back
  function automatic step_t hold(input step_t x, input logic [7:0] c, input logic starts);
    step_t y;
    y = x;
    if (!x.s.hc[1]) begin
      if (x.s.hc == 2'd0) begin
        y.s.h0 = c;
      end else begin
        y.s.h1 = c;
      end
      y.s.hc = x.s.hc + 2'd1;
    end
    if (starts) begin
      y.s.hs = 1'b1;
    end
    return y;
  endfunction

  // byte between tokens
  function automatic step_t idle_take(input step_t x, input logic [7:0] c);
    step_t y;
    y = x;
    y.s.mode = MODE_IDLE;
    y.s.hc   = 2'd0;
    y.s.hs   = 1'b0;
    y.s.ps   = 1'b0;
    if (!is_space(c)) begin
      priority if (c == CH_SEMI) begin
        y.s.mode = MODE_COMMENT;
      end else if (c == CH_OPEN) begin
        y = push(y, KIND_OPEN, c, 1'b1, 1'b1, 1'b0);
      end else if (c == CH_CLOSE) begin
        y = push(y, KIND_CLOSE, c, 1'b1, 1'b1, 1'b0);
      end else if (c == CH_QUOTE) begin
        y = push(y, KIND_QUOTE, c, 1'b1, 1'b1, 1'b0);
      end else if (c == CH_DQUOTE) begin
        y.s.mode = MODE_STRING;
      end else if (c == CH_MINUS) begin
        y = hold(y, c, 1'b1);
        y.s.mode = MODE_MINUS;
      end else if (c == CH_POINT) begin
        y = hold(y, c, 1'b1);
        y.s.ps   = 1'b1;
        y.s.mode = MODE_POINT;
      end else if (is_digit(c)) begin
        y = hold(y, c, 1'b1);
        y.s.mode = MODE_NUMBER;
      end else if (c == CH_HASH) begin
        y = hold(y, c, 1'b1);
        y.s.mode = MODE_HASH;
      end else begin
        y = hold(y, c, 1'b1);
        y.s.mode = MODE_ATOM;
      end
    end
    return y;
  endfunction

  // atom goes on or ends at a delimiter
  function automatic step_t atom_continue(input step_t x, input logic [7:0] c);
    step_t y;
    y = x;
    y.s.mode = MODE_ATOM;
    if (is_delim(c)) begin
      y = emit_held(y, KIND_ATOM, 1'b1);
      y = idle_take(y, c);
    end else begin
      y = emit_held(y, KIND_ATOM, 1'b0);
      y = hold(y, c, 1'b0);
    end
    return y;
  endfunction

  function automatic step_t start_number(input step_t x, input logic [7:0] c);
    step_t y;
    y = emit_held(x, KIND_NUMBER, 1'b0);
    y = hold(y, c, 1'b0);
    y.s.mode = MODE_NUMBER;
    return y;
  endfunction

  // one byte through the mode machine
  function automatic step_t take(input step_t x, input logic [7:0] c);
    step_t y;
    y = x;
    unique case (x.s.mode)
      MODE_COMMENT: begin
        if (c == CH_NL) begin
          y.s.mode = MODE_IDLE;
        end
      end
      MODE_MINUS: begin
        priority if (is_digit(c)) begin
          y = start_number(y, c);
        end else if (c == CH_POINT) begin
          y = hold(y, c, 1'b0);
          y.s.ps   = 1'b1;
          y.s.mode = MODE_POINT;
        end else begin
          y = atom_continue(y, c);
        end
      end
      MODE_POINT: begin
        if (is_digit(c)) begin
          y = start_number(y, c);
        end else begin
          y = atom_continue(y, c);
        end
      end
      MODE_NUMBER: begin
        priority if (is_digit(c)) begin
          y = emit_held(y, KIND_NUMBER, 1'b0);
          y = hold(y, c, 1'b0);
        end else if (c == CH_POINT && !x.s.ps) begin
          y = emit_held(y, KIND_NUMBER, 1'b0);
          y = hold(y, c, 1'b0);
          y.s.ps = 1'b1;
        end else begin
          y = emit_held(y, KIND_NUMBER, 1'b1);
          y = idle_take(y, c);
        end
      end
      MODE_HASH: begin
        if (c == CH_T || c == CH_F) begin
          y = push(y, KIND_BOOL, c, 1'b1, 1'b1, 1'b0);
          y.s.hc   = 2'd0;
          y.s.hs   = 1'b0;
          y.s.mode = MODE_IDLE;
        end else begin
          y = atom_continue(y, c);
        end
      end
      MODE_ATOM: begin
        y = atom_continue(y, c);
      end
      MODE_STRING: begin
        priority if (c == CH_DQUOTE) begin
          if (x.s.hc == 2'd0) begin
            y = push(y, KIND_STRING, 8'h00, 1'b1, 1'b1, 1'b1);
          end else begin
            y = emit_held(y, KIND_STRING, 1'b1);
          end
          y.s.mode = MODE_IDLE;
        end else if (x.s.hc == 2'd0) begin
          y = hold(y, c, 1'b1);
        end else begin
          y = emit_held(y, KIND_STRING, 1'b0);
          y = hold(y, c, 1'b0);
        end
      end
      default: begin
        y = idle_take(y, c);
      end
    endcase
    return y;
  endfunction

  // end of text: close whatever is pending
  function automatic step_t finish(input step_t x);
    step_t y;
    y = x;
    unique case (x.s.mode)
      MODE_NUMBER: begin
        y = emit_held(y, KIND_NUMBER, 1'b1);
      end
      MODE_MINUS, MODE_POINT, MODE_HASH, MODE_ATOM: begin
        y = emit_held(y, KIND_ATOM, 1'b1);
      end
      MODE_STRING: begin
        if (x.s.hc == 2'd0) begin
          y = push(y, KIND_STRING, 8'h00, 1'b1, 1'b1, 1'b1);
        end else begin
          y = emit_held(y, KIND_STRING, 1'b1);
        end
      end
      default: begin
      end
    endcase
    y.s.mode = MODE_IDLE;
    y.s.hc   = 2'd0;
    y.s.hs   = 1'b0;
    y.s.ps   = 1'b0;
    return y;
  endfunction

  lex_st_t            st;
  step_t              stp;
  logic               in_fire;
  logic               pop;
  logic [1:0]         push_n;
  res_t               q [Q_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  res_t               head;

  // lex the incoming byte
  always_comb begin
    stp.s = st;
    stp.r = '0;
    stp.n = 2'd0;
    stp   = take(stp, s_tdata);
    if (s_tlast) begin
      stp = finish(stp);
    end
    if (stp.n != 2'd0) begin
      stp.r[stp.n - 2'd1].run_last = 1'b1;
    end
  end

  // handshakes
  assign s_tready = count <= CNT_W'(Q_DEPTH - MAX_RESULTS);
  assign in_fire  = s_tvalid && s_tready;
  assign m_tvalid = count != '0;
  assign pop      = m_tvalid && m_tready;
  assign push_n   = in_fire ? stp.n : 2'd0;

  // lexer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode <= MODE_IDLE;
      st.hc   <= 2'd0;
      st.hs   <= 1'b0;
      st.ps   <= 1'b0;
    end else if (in_fire) begin
      st <= stp.s;
    end
  end

  // result queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push_n);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (in_fire && 2'(i) < stp.n) begin
        q[wptr + PTR_W'(i)] <= stp.r[i];
      end
    end
  end

  // output word
  assign head    = q[rptr];
  assign m_tdata = head.lex;
  assign m_tuser = {head.empty, head.last, head.first, head.kind};
  assign m_tlast = head.run_last;

endmodule

[rtl/core/stl_checker.sv]
module stl_checker
  import stl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,   // [7:0] character
  input logic       s_tlast,   // end_of_text
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,   // [7:0] lexeme_byte
  input logic [5:0] m_tuser,   // [2:0] token_kind, [3] token_first, [4] token_last,
                               // [5] empty_lexeme
  input logic       m_tlast    // run_last
);

  // a stalled output word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word withdrawn while stalled");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // input only stalls while results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with an empty result queue");

  // the empty string word is a lone string token with a zero byte
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[5] |->
      m_tuser[3] && m_tuser[4] && m_tuser[2:0] == KIND_STRING && m_tdata == 8'h00)
    else $error("malformed empty string word");

  // single character tokens open and close on one word
  a_single_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == KIND_BOOL || m_tuser[2:0] == KIND_OPEN ||
                 m_tuser[2:0] == KIND_CLOSE || m_tuser[2:0] == KIND_QUOTE) |->
      m_tuser[3] && m_tuser[4])
    else $error("single character token without first and last marks");

endmodule

bind sexpr_token_lexer_top stl_checker u_stl_checker (.*);

[sim/lexeme_checker.sv]
module lexeme_checker
  import stl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] character
  input  logic       s_tlast,   // end_of_text
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] lexeme_byte
  input  logic [5:0] m_tuser,   // [2:0] token_kind, [3] token_first, [4] token_last,
                                // [5] empty_lexeme
  input  logic       m_tlast,   // run_last
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // words still owed by the block, oldest first
  res_t expected_words[$];
  int   fail_count = 0;
  int   byte_words;

  // shadow lexer state
  mode_t      lx_mode;
  logic [7:0] lx_held [2];
  logic [1:0] lx_count;
  logic       lx_first_held;
  logic       lx_point;

  assign errors = fail_count;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return is_blank(c) || c == CH_OPEN || c == CH_CLOSE;
  endfunction

  // one lexeme word; a byte never yields more than the block can hold
  function automatic void put_word(kind_t k, logic [7:0] b, bit first, bit last,
                                   bit empty);
    res_t w;
    if (byte_words < MAX_RESULTS) begin
      w.empty    = empty;
      w.last     = last;
      w.first    = first;
      w.kind     = k;
      w.lex      = b;
      w.run_last = 1'b0;
      expected_words.push_back(w);
    end
    byte_words++;
  endfunction

  // flush the held characters; the final one closes the token if asked
  function automatic void release_held(kind_t k, bit ends);
    for (int i = 0; i < lx_count; i++)
      put_word(k, lx_held[i], i == 0 && lx_first_held, ends && i + 1 == lx_count, 1'b0);
    lx_count      = 2'd0;
    lx_first_held = 1'b0;
  endfunction

  function automatic void keep(logic [7:0] c, bit starts);
    if (lx_count < 2'd2) begin
      lx_held[lx_count] = c;
      lx_count++;
    end
    if (starts)
      lx_first_held = 1'b1;
  endfunction

  function automatic void close_string();
    if (lx_count == 2'd0)
      put_word(KIND_STRING, 8'h00, 1'b1, 1'b1, 1'b1);
    else
      release_held(KIND_STRING, 1'b1);
  endfunction

  // a byte seen between tokens
  function automatic void start_token(logic [7:0] c);
    lx_mode       = MODE_IDLE;
    lx_count      = 2'd0;
    lx_first_held = 1'b0;
    lx_point      = 1'b0;
    if (is_blank(c))
      return;
    if (c == CH_SEMI) begin
      lx_mode = MODE_COMMENT;
    end else if (c == CH_OPEN) begin
      put_word(KIND_OPEN, c, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_CLOSE) begin
      put_word(KIND_CLOSE, c, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_QUOTE) begin
      put_word(KIND_QUOTE, c, 1'b1, 1'b1, 1'b0);
    end else if (c == CH_DQUOTE) begin
      lx_mode = MODE_STRING;
    end else if (c == CH_MINUS) begin
      keep(c, 1'b1);
      lx_mode = MODE_MINUS;
    end else if (c == CH_POINT) begin
      keep(c, 1'b1);
      lx_point = 1'b1;
      lx_mode  = MODE_POINT;
    end else if (is_digit(c)) begin
      keep(c, 1'b1);
      lx_mode = MODE_NUMBER;
    end else if (c == CH_HASH) begin
      keep(c, 1'b1);
      lx_mode = MODE_HASH;
    end else begin
      keep(c, 1'b1);
      lx_mode = MODE_ATOM;
    end
  endfunction

  // atom goes on until a delimiter, which is then lexed afresh
  function automatic void extend_atom(logic [7:0] c);
    lx_mode = MODE_ATOM;
    if (is_delim(c)) begin
      release_held(KIND_ATOM, 1'b1);
      start_token(c);
    end else begin
      release_held(KIND_ATOM, 1'b0);
      keep(c, 1'b0);
    end
  endfunction

  // expected words for one source byte
  function automatic void predict_byte(logic [7:0] c, logic eot);
    int   size_prior;
    res_t tail;
    size_prior = expected_words.size();
    byte_words = 0;
    case (lx_mode)
      MODE_COMMENT: begin
        if (c == CH_NL)
          lx_mode = MODE_IDLE;
      end
      MODE_MINUS: begin
        if (is_digit(c)) begin
          release_held(KIND_NUMBER, 1'b0);
          keep(c, 1'b0);
          lx_mode = MODE_NUMBER;
        end else if (c == CH_POINT) begin
          keep(c, 1'b0);
          lx_point = 1'b1;
          lx_mode  = MODE_POINT;
        end else begin
          extend_atom(c);
        end
      end
      MODE_POINT: begin
        if (is_digit(c)) begin
          release_held(KIND_NUMBER, 1'b0);
          keep(c, 1'b0);
          lx_mode = MODE_NUMBER;
        end else begin
          extend_atom(c);
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          release_held(KIND_NUMBER, 1'b0);
          keep(c, 1'b0);
        end else if (c == CH_POINT && !lx_point) begin
          release_held(KIND_NUMBER, 1'b0);
          keep(c, 1'b0);
          lx_point = 1'b1;
        end else begin
          release_held(KIND_NUMBER, 1'b1);
          start_token(c);
        end
      end
      MODE_HASH: begin
        if (c == CH_T || c == CH_F) begin
          put_word(KIND_BOOL, c, 1'b1, 1'b1, 1'b0);
          lx_count      = 2'd0;
          lx_first_held = 1'b0;
          lx_mode       = MODE_IDLE;
        end else begin
          extend_atom(c);
        end
      end
      MODE_ATOM: extend_atom(c);
      MODE_STRING: begin
        if (c == CH_DQUOTE) begin
          close_string();
          lx_mode = MODE_IDLE;
        end else if (lx_count == 2'd0) begin
          keep(c, 1'b1);
        end else begin
          release_held(KIND_STRING, 1'b0);
          keep(c, 1'b0);
        end
      end
      default: start_token(c);
    endcase

    // end of text completes whatever is pending; a comment just goes away
    if (eot) begin
      case (lx_mode)
        MODE_NUMBER: release_held(KIND_NUMBER, 1'b1);
        MODE_MINUS, MODE_POINT, MODE_HASH, MODE_ATOM: release_held(KIND_ATOM, 1'b1);
        MODE_STRING: close_string();
        default: ;
      endcase
      lx_mode       = MODE_IDLE;
      lx_count      = 2'd0;
      lx_first_held = 1'b0;
      lx_point      = 1'b0;
    end

    // last word of this byte carries the run mark
    if (expected_words.size() > size_prior) begin
      tail          = expected_words.pop_back();
      tail.run_last = 1'b1;
      expected_words.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(string note, res_t want);
    $display("%0t %s: got kind %0d byte %02h f%b l%b e%b r%b, %s %0d byte %02h f%b l%b e%b r%b",
             $time, note, m_tuser[2:0], m_tdata, m_tuser[3], m_tuser[4], m_tuser[5],
             m_tlast, "want kind", want.kind, want.lex, want.first, want.last,
             want.empty, want.run_last);
    fail_count++;
  endtask

  // outgoing word checked before the incoming byte is predicted
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      expected_words.delete();
      lx_mode       = MODE_IDLE;
      lx_count      = 2'd0;
      lx_first_held = 1'b0;
      lx_point      = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          want = '0;
          report_mismatch("word with none expected", want);
        end else begin
          want = expected_words.pop_front();
          if (m_tdata !== want.lex || m_tuser[2:0] !== want.kind ||
              m_tuser[3] !== want.first || m_tuser[4] !== want.last ||
              m_tuser[5] !== want.empty || m_tlast !== want.run_last)
            report_mismatch("word mismatch", want);
        end
      end
      if (s_tvalid && s_tready)
        predict_byte(s_tdata, s_tlast);
    end
    pending <= expected_words.size();
  end

endmodule

[sim/sexpr_token_lexer_top_tb.sv]
module sexpr_token_lexer_top_tb
  import stl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;   // [7:0] character
  logic       s_tlast  = 1'b0;    // end_of_text
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [7:0] lexeme_byte
  logic [5:0] m_tuser;            // [2:0] token_kind, [3] token_first, [4] token_last,
                                  // [5] empty_lexeme
  logic       m_tlast;            // run_last

  int   fail_total;
  int   words_pending;
  bit   tx_gaps     = 1'b0;
  bit   rx_gaps     = 1'b0;
  int   stall_left  = 0;
  int   token_bytes = 0;

  logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
  string      symbols    = "+*/<=>!?_:.-#";

  sexpr_token_lexer_top DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  lexeme_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .errors  (fail_total),
    .pending (words_pending)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver stalls in bursts of random length when rx_gaps is set
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 5) == 0)
      return 8'($urandom_range(128, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] rand_atom_char();
    case ($urandom_range(0, 5))
      0: return rand_digit();
      1: return symbols[$urandom_range(0, symbols.len() - 1)];
      default: return rand_letter();
    endcase
  endfunction

  function automatic logic [7:0] rand_text_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(8'h20, 8'h7E)); while (ch == CH_DQUOTE);
    return ch;
  endfunction

  // one source byte, with an optional gap before it
  task automatic send_byte(input logic [7:0] c, input bit eot);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eot_last && i == s.len() - 1);
  endtask

  // hold the sender until every expected word has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  // one random token, mostly well formed, sometimes broken or plain noise
  task automatic send_token();
    logic [7:0] txt[$];
    int         pick;
    bit         end_here;
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2, 3: begin
        if ($urandom_range(0, 2) == 0) txt.push_back(CH_MINUS);
        if ($urandom_range(0, 5) == 0) txt.push_back(CH_POINT);
        repeat ($urandom_range(1, 4)) txt.push_back(rand_digit());
        if ($urandom_range(0, 2) == 0) begin
          txt.push_back(CH_POINT);
          repeat ($urandom_range(0, 3)) txt.push_back(rand_digit());
          if ($urandom_range(0, 5) == 0) txt.push_back(CH_POINT);
        end
      end
      4: begin
        txt.push_back(CH_HASH);
        txt.push_back($urandom_range(0, 1) ? CH_T : CH_F);
      end
      5: txt.push_back(CH_OPEN);
      6: txt.push_back(CH_CLOSE);
      7: txt.push_back(CH_QUOTE);
      8, 9: begin
        txt.push_back(CH_DQUOTE);
        repeat ($urandom_range(0, 5))
          txt.push_back($urandom_range(0, 7) == 0 ? rand_letter() : rand_text_char());
        if ($urandom_range(0, 7) != 0) txt.push_back(CH_DQUOTE);
      end
      10, 11, 12: begin
        txt.push_back(rand_letter());
        repeat ($urandom_range(0, 4)) txt.push_back(rand_atom_char());
      end
      13: begin
        repeat ($urandom_range(1, 2)) begin
          txt.push_back(CH_SEMI);
          repeat ($urandom_range(0, 6)) txt.push_back(rand_text_char());
          txt.push_back(CH_NL);
        end
      end
      14: repeat ($urandom_range(1, 3)) txt.push_back(blanks[$urandom_range(0, 5)]);
      15, 16: begin
        case ($urandom_range(0, 3))
          0: txt.push_back(CH_MINUS);
          1: txt.push_back(CH_POINT);
          2: txt.push_back(CH_HASH);
          default: begin
            txt.push_back(CH_MINUS);
            txt.push_back(CH_POINT);
          end
        endcase
        case ($urandom_range(0, 6))
          0: txt.push_back(blanks[$urandom_range(0, 5)]);
          1: txt.push_back(CH_OPEN);
          2: txt.push_back(CH_CLOSE);
          3: txt.push_back(CH_DQUOTE);
          4: txt.push_back(CH_SEMI);
          5: txt.push_back(rand_digit());
          default: txt.push_back(rand_letter());
        endcase
      end
      default: repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 3) != 0)
      txt.push_back(blanks[$urandom_range(0, 5)]);
    if (pick != 13 && pick != 14)
      token_bytes += txt.size();
    end_here = $urandom_range(0, 11) == 0;
    foreach (txt[i])
      send_byte(txt[i], end_here && i == txt.size() - 1);
  endtask

  // stimulus and verdict
  initial begin
    int next_drain;
    int wait_cycles;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: single-character tokens, byte extremes, hash, booleans,
    // second point, empty and unterminated strings, comment at end of text
    send_text("()'", 1'b1);
    send_byte(CH_MINUS, 1'b0);
    send_byte(CH_POINT, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("#tx #q)", 1'b0);
    send_text("-1.2.5 ", 1'b0);
    send_text("\"\";z", 1'b1);
    send_text("\"a", 1'b1);
    send_text("\"", 1'b1);
    rx_gaps <= 1'b1;
    drain();

    // random token stream, quiet toward the end
    tx_gaps = 1'b1;
    next_drain = 130;
    while (token_bytes < 400) begin
      if (token_bytes >= 340) begin
        tx_gaps = 1'b0;
        rx_gaps <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        tx_gaps = 1'($urandom_range(0, 1));
        rx_gaps <= 1'($urandom_range(0, 1));
      end
      if (token_bytes >= next_drain) begin
        drain();
        next_drain += 130;
      end
      send_token();
    end

    // let the output empty, then a short tail for stray words
    s_tvalid    <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (words_pending != 0 && wait_cycles < 20000);
    repeat (16) @(posedge clk);
    if (fail_total == 0 && words_pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/core/stl_pkg.sv
rtl/core/sexpr_token_lexer_top.sv
rtl/core/stl_checker.sv
sim/lexeme_checker.sv
sim/sexpr_token_lexer_top_tb.sv
